FILE: sv/keyboard_packet_to_char_assert.svh
// Assertion macros shared by the checker file of keyboard_packet_to_char.
// Depends on nothing; the including scope provides clock and reset.
`ifndef KEYBOARD_PACKET_TO_CHAR_ASSERT_SVH
`define KEYBOARD_PACKET_TO_CHAR_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define KPC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define KPC_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/kpc_pkg.sv
// Shared types and constants for the keyboard packet to character translator.
// Depends on nothing.
package kpc_pkg;

   localparam int KEY_CODES    = 128;
   localparam int CHAR_W       = 8;
   localparam int CODE_W       = 7;
   localparam int COUNT_W      = 8;

   localparam logic [7:0] HDR_MASK    = 8'hbf;
   localparam logic [7:0] HDR_PATTERN = 8'h94;
   localparam logic [7:0] CTRL_MASK   = 8'h1f;
   localparam logic [7:0] CASE_BIT    = 8'h20;

   localparam logic [CODE_W-1:0]  SHIFT_L_KEY = 7'o061;
   localparam logic [CODE_W-1:0]  SHIFT_R_KEY = 7'o062;
   localparam logic [CODE_W-1:0]  CTRL_L_KEY  = 7'o034;
   localparam logic [CODE_W-1:0]  CTRL_R_KEY  = 7'o124;
   localparam logic [CODE_W-1:0]  CAPS_KEY    = 7'o011;

   localparam logic [COUNT_W-1:0] RESET_REPEAT_DELAY = 8'd5;
   localparam logic [COUNT_W-1:0] COUNT_MAX          = 8'hff;

   typedef enum logic [1:0] {
      OP_SERIAL     = 2'd0,
      OP_WR_PLAIN   = 2'd1,
      OP_WR_SHIFTED = 2'd2,
      OP_UNUSED     = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_NO_KEY_CODE  = 1'b0,
      CSR_REPEAT_DELAY = 1'b1
   } csr_index_type;

   // Item from the item register, with its advance strobe, handed to the key state logic.
   typedef struct packed {
      logic              fire;
      op_type            opcode;
      logic [7:0]        rx_byte;
      logic              rx_error;
   } kpc_item_type;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] character;
   } kpc_result_type;

endpackage

FILE: sv/keyboard_packet_to_char.sv
// Keyboard packet to character translator: top level with the stream ports.
// Depends on kpc_pkg, kpc_map_mem and kpc_key_state.
//
// Takes one transfer per clock unless the result side stalls with an item
// waiting: serial keyboard bytes (two-byte packets, a header matching 0x94
// under mask 0xbf, bit 6 marking a release, then the scan code; a zero code
// marks all keys up) and table write items that load the plain and the
// shifted character tables. Each accepted item produces at most one
// character transfer, through the item register and then the result
// register. The tables are read at the acceptance edge, so the rate is set
// by the single read port of each table plus one pass through the key state
// logic. Table entries must be written before any key that reads them is
// pressed. Registers: index 0 no-key code (reset 0), index 1 repeat delay
// (reset 5); write them only while no item is in flight.
module keyboard_packet_to_char
   import kpc_pkg::*;
#(
   parameter int KeyCodes = KEY_CODES,
   localparam int IdxW    = $clog2(KeyCodes)
) (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // rx_byte[7:0], table_index[14:8], table_value[22:15]
   input  logic [2:0]  req_tuser,   // opcode[1:0], rx_error[2]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // character[7:0]
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // register file
   logic [CHAR_W-1:0]  no_key_ff;
   logic [COUNT_W-1:0] delay_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         no_key_ff <= '0;
         delay_ff  <= RESET_REPEAT_DELAY;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_NO_KEY_CODE:  no_key_ff <= csr_data;
            CSR_REPEAT_DELAY: delay_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // unpack the input transfer
   op_type            in_opcode;
   logic [7:0]        in_byte;
   logic              in_error;
   logic [CODE_W-1:0] in_index;
   logic [7:0]        in_value;

   assign in_byte   = req_tdata[7:0];
   assign in_index  = req_tdata[14:8];
   assign in_value  = req_tdata[22:15];
   assign in_opcode = op_type'(req_tuser[1:0]);
   assign in_error  = req_tuser[2];

   // item register
   logic   s1_valid_ff, s1_valid_in;
   op_type s1_opcode_ff;
   logic [7:0] s1_byte_ff;
   logic   s1_error_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_data_ff;

   // handshake: the item stage advances whenever the result register is free
   logic out_free;
   logic advance;
   logic accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_opcode_ff <= in_opcode;
         s1_byte_ff   <= in_byte;
         s1_error_ff  <= in_error;
      end
   end

   // character tables: write on acceptance of a write item, read the entry
   // of the incoming byte's code so it travels with the item
   logic [CHAR_W-1:0] plain_rd;
   logic [CHAR_W-1:0] shifted_rd;

   kpc_map_mem #(.KeyCodes(KeyCodes)) u_plain (
      .clock   (clock),
      .wr_en   (accept && (in_opcode == OP_WR_PLAIN)),
      .wr_addr (in_index[IdxW-1:0]),
      .wr_data (in_value),
      .rd_en   (accept),
      .rd_addr (in_byte[IdxW-1:0]),
      .rd_data (plain_rd)
   );

   kpc_map_mem #(.KeyCodes(KeyCodes)) u_shifted (
      .clock   (clock),
      .wr_en   (accept && (in_opcode == OP_WR_SHIFTED)),
      .wr_addr (in_index[IdxW-1:0]),
      .wr_data (in_value),
      .rd_en   (accept),
      .rd_addr (in_byte[IdxW-1:0]),
      .rd_data (shifted_rd)
   );

   // key state and translation
   kpc_item_type   item;
   kpc_result_type result;

   assign item.fire     = advance;
   assign item.opcode   = s1_opcode_ff;
   assign item.rx_byte  = s1_byte_ff;
   assign item.rx_error = s1_error_ff;

   kpc_key_state #(.KeyCodes(KeyCodes)) u_state (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .plain_data   (plain_rd),
      .shifted_data (shifted_rd),
      .no_key_code  (no_key_ff),
      .repeat_delay (delay_ff),
      .result       (result)
   );

   // result register: load on advance, drop once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = result.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_data_ff <= result.character;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sv/kpc_map_mem.sv
// One character table: single write port and one registered read port.
// Depends on kpc_pkg.
module kpc_map_mem
   import kpc_pkg::*;
#(
   parameter int KeyCodes = KEY_CODES,
   localparam int IdxW    = $clog2(KeyCodes)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IdxW-1:0]   wr_addr,
   input  logic [CHAR_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IdxW-1:0]   rd_addr,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem_ff [KeyCodes];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/kpc_key_state.sv
// Packet parser, key down map, repeat counter, caps lock and translation.
// Depends on kpc_pkg.
module kpc_key_state
   import kpc_pkg::*;
#(
   parameter int KeyCodes = KEY_CODES,
   localparam int IdxW    = $clog2(KeyCodes)
) (
   input  logic               clock,
   input  logic               reset,
   input  kpc_item_type       item,
   input  logic [CHAR_W-1:0]  plain_data,
   input  logic [CHAR_W-1:0]  shifted_data,
   input  logic [CHAR_W-1:0]  no_key_code,
   input  logic [COUNT_W-1:0] repeat_delay,
   output kpc_result_type     result
);

   logic                second_ff, second_in;
   logic                release_ff, release_in;
   logic [KeyCodes-1:0] key_down_ff, key_down_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                caps_ff, caps_in;

   logic                serial;
   logic                is_release;
   logic [CODE_W-1:0]   code;
   logic [IdxW-1:0]     key;
   logic                was_down;
   logic                shift_dn;
   logic                ctrl_dn;
   logic [CHAR_W-1:0]   ch;

   // the no-key compare uses the table entry before caps and control
   // adjustments; keep that order by comparing the raw entry
   logic [CHAR_W-1:0]   raw_entry;

   always_comb begin
      second_in   = second_ff;
      release_in  = release_ff;
      key_down_in = key_down_ff;
      count_in    = count_ff;
      caps_in     = caps_ff;
      result      = '0;

      serial     = item.fire && (item.opcode == OP_SERIAL) && !item.rx_error;
      code       = item.rx_byte[CODE_W-1:0];
      key        = code[IdxW-1:0];
      is_release = item.rx_byte[7] || release_ff;
      was_down   = key_down_ff[key];
      // the key being pressed counts as down for the modifier test
      shift_dn   = key_down_ff[SHIFT_L_KEY[IdxW-1:0]] || key_down_ff[SHIFT_R_KEY[IdxW-1:0]]
                   || (code == SHIFT_L_KEY) || (code == SHIFT_R_KEY);
      ctrl_dn    = key_down_ff[CTRL_L_KEY[IdxW-1:0]] || key_down_ff[CTRL_R_KEY[IdxW-1:0]]
                   || (code == CTRL_L_KEY) || (code == CTRL_R_KEY);
      ch         = shift_dn ? shifted_data : plain_data;
      if (caps_ff && (ch >= "a") && (ch <= "z")) begin
         ch = ch & ~CASE_BIT;
      end
      if (ctrl_dn) begin
         ch = ch & CTRL_MASK;
      end

      if (serial && !second_ff) begin
         release_in = item.rx_byte[6];
         second_in  = (item.rx_byte & HDR_MASK) == HDR_PATTERN;
      end else if (serial) begin
         second_in = 1'b0;
         if (item.rx_byte == 8'd0) begin
            key_down_in = '0;
         end else if (is_release) begin
            key_down_in[key] = 1'b0;
         end else if (was_down && (count_ff < repeat_delay)) begin
            // held key still inside the repeat delay: count and drop
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (was_down) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               count_in = '0;
            end
            key_down_in[key] = 1'b1;
            if (code == CAPS_KEY) begin
               caps_in = !caps_ff;
            end else if (raw_entry != no_key_code) begin
               result.valid     = 1'b1;
               result.character = ch;
            end
         end
      end
   end

   assign raw_entry = shift_dn ? shifted_data : plain_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff   <= 1'b0;
         release_ff  <= 1'b0;
         key_down_ff <= '0;
         count_ff    <= '0;
         caps_ff     <= 1'b0;
      end else begin
         second_ff   <= second_in;
         release_ff  <= release_in;
         key_down_ff <= key_down_in;
         count_ff    <= count_in;
         caps_ff     <= caps_in;
      end
   end

endmodule

FILE: sv/kpc_checker.sv
// Port-level checks for keyboard_packet_to_char, bound to the top level.
// Depends on keyboard_packet_to_char_assert.svh.
`include "keyboard_packet_to_char_assert.svh"

module kpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [0:0]  csr_index,
   input logic [7:0]  csr_data
);

   // a stalled character stays valid and holds its value
   `KPC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "stalled character dropped")
   `KPC_ASSERT(a_rsp_data, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "stalled data changed")

   // no character right after reset
   `KPC_ASSERT(a_rsp_reset, $fell(reset) |-> !rsp_tvalid, "character shown right after reset")

   // input side never stalls while the result side takes transfers
   `KPC_ASSERT(a_req_flow, rsp_tready |-> req_tready, "input stalled with result side ready")

   // register writes are always taken
   `KPC_ASSERT_ALWAYS(a_csr_ready, csr_valid |-> csr_ready, "register write stalled")

endmodule

bind keyboard_packet_to_char kpc_checker u_kpc_checker (.*);
